// ----- hdl/pma_pkg.sv -----
package pma_pkg;

  // field widths
  localparam int unsigned ProbW  = 8;
  localparam int unsigned CntW   = 8;
  localparam int unsigned TotW   = CntW + 1;
  localparam int unsigned MeasQW = TotW;   // measured quotient reaches 256
  localparam int unsigned FacQW  = ProbW;  // blend factor stays below 256

  // pipeline shape: one restoring step per divide stage
  localparam int unsigned DivSteps = MeasQW;
  localparam int unsigned NumStg   = DivSteps + 4;

  localparam logic [ProbW-1:0]  ProbHalf = 8'd128;
  localparam logic [ProbW-1:0]  ProbMax  = 8'd255;
  localparam logic [ProbW-1:0]  ProbMin  = 8'd1;
  localparam logic [ProbW:0]    ProbOne  = 9'd256;

  // one item in flight through the divide stages
  typedef struct packed {
    logic [ProbW-1:0]  old;
    logic [TotW-1:0]   m_div;
    logic [TotW-1:0]   m_rem;
    logic [MeasQW-1:0] m_low;
    logic [CntW-1:0]   f_div;
    logic [CntW-1:0]   f_rem;
    logic [FacQW-1:0]  f_low;
    logic              tot_zero;
    logic              sat_zero;
  } pma_div_t;

endpackage

// ----- hdl/probability_merge_adapt_unit.sv -----
// Backward probability adaptation for one binary-tree node.
//
// Input channel (in_valid_i / in_stall_o) carries the prior probability, the
// two branch counts, the saturation count and the update limit. An item is
// taken on a rising edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i) returns one item per input item:
// the adapted probability and a flag for a zero saturation count, in order.
//
// An item passes two stages of setup (sum, clamp, numerator product), nine
// restoring divide stages that retire one measured-quotient bit each, all
// but the last also a blend-factor bit, one product and one blend stage.
// Throughput is one item per cycle unless stalled; divide stages set depth.
//
// Every stage carries its own valid bit. A stage loads whenever it is empty
// or the stage after it moves, so bubbles close up while the receiver stalls
// and the input keeps taking items until the pipe is full.
// Reset clears every valid bit; payload registers are not reset.
module probability_merge_adapt_unit
  import pma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ProbW-1:0] old_probability_i,
  input  logic [CntW-1:0]  zero_count_i,
  input  logic [CntW-1:0]  one_count_i,
  input  logic [CntW-1:0]  saturation_count_i,
  input  logic [ProbW-1:0] update_limit_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ProbW-1:0] new_probability_o,
  output logic             bad_saturation_o
);

  // Stage map of the valid bits:
  //   0            sum and raw fields
  //   1 .. 10      divider entry and nine divide steps (dv_q[0..9])
  //   11           blend products
  //   12           rounded blend, output register
  localparam int unsigned StgDv0  = 1;
  localparam int unsigned StgMul  = StgDv0 + DivSteps + 1;
  localparam int unsigned StgOut  = StgMul + 1;

  // One restoring step of the measured-probability divider.
  function automatic pma_div_t meas_step(input pma_div_t a);
    pma_div_t        r;
    logic [TotW:0]   t;
    logic            qb;
    r  = a;
    t  = {a.m_rem, a.m_low[MeasQW-1]};
    qb = (t >= {1'b0, a.m_div});
    r.m_rem = qb ? TotW'(t - {1'b0, a.m_div}) : t[TotW-1:0];
    r.m_low = {a.m_low[MeasQW-2:0], qb};
    return r;
  endfunction

  // One restoring step of the blend-factor divider.
  function automatic pma_div_t fac_step(input pma_div_t a);
    pma_div_t        r;
    logic [CntW:0]   t;
    logic            qb;
    r  = a;
    t  = {a.f_rem, a.f_low[FacQW-1]};
    qb = (t >= {1'b0, a.f_div});
    r.f_rem = qb ? CntW'(t - {1'b0, a.f_div}) : t[CntW-1:0];
    r.f_low = {a.f_low[FacQW-2:0], qb};
    return r;
  endfunction

  // ---------------------------------------------------------------- control
  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   rdy;

  always_comb begin
    rdy[NumStg] = !out_stall_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic [ProbW-1:0] s0_old_q;
  logic [CntW-1:0]  s0_zero_q, s0_sat_q;
  logic [ProbW-1:0] s0_lim_q;
  logic [TotW-1:0]  s0_tot_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s0_old_q  <= old_probability_i;
      s0_zero_q <= zero_count_i;
      s0_sat_q  <= saturation_count_i;
      s0_lim_q  <= update_limit_i;
      s0_tot_q  <= {1'b0, zero_count_i} + {1'b0, one_count_i};
    end
  end

  // ---------------------------------------------------------------- divider entry
  // Both quotients fit the step count, so the top numerator bits already sit
  // below the divisor and seed the partial remainders.
  logic [CntW-1:0]       cnt;
  logic [2*CntW-1:0]     fac_num;
  logic [CntW+ProbW:0]   meas_num;
  pma_div_t              dv_init;
  pma_div_t              dv_q [DivSteps+1];

  always_comb begin
    cnt      = (s0_tot_q < {1'b0, s0_sat_q}) ? s0_tot_q[CntW-1:0] : s0_sat_q;
    fac_num  = s0_lim_q * cnt;
    meas_num = {s0_zero_q, {ProbW{1'b0}}} + (CntW+ProbW+1)'(s0_tot_q >> 1);

    dv_init          = '0;
    dv_init.old      = s0_old_q;
    dv_init.m_div    = s0_tot_q;
    dv_init.m_rem    = {1'b0, meas_num[CntW+ProbW -: CntW]};
    dv_init.m_low    = meas_num[MeasQW-1:0];
    dv_init.f_div    = s0_sat_q;
    dv_init.f_rem    = fac_num[2*CntW-1 -: CntW];
    dv_init.f_low    = fac_num[FacQW-1:0];
    dv_init.tot_zero = (s0_tot_q == '0);
    dv_init.sat_zero = (s0_sat_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgDv0] && v_q[StgDv0-1]) begin
      dv_q[0] <= dv_init;
    end
  end

  // ---------------------------------------------------------------- divide stages
  for (genvar j = 1; j <= DivSteps; j++) begin : g_div
    pma_div_t nxt;
    always_comb begin
      nxt = meas_step(dv_q[j-1]);
      if (j <= FacQW) begin
        nxt = fac_step(nxt);
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[StgDv0+j] && v_q[StgDv0+j-1]) begin
        dv_q[j] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------- products
  pma_div_t              dv_last;
  logic [MeasQW-1:0]     mq;
  logic [ProbW-1:0]      meas;
  logic [ProbW:0]        old_w;
  logic [2*ProbW:0]      pa_q;
  logic [2*ProbW-1:0]    pb_q;
  logic [ProbW-1:0]      s11_old_q;
  logic                  s11_bad_q;

  always_comb begin
    dv_last = dv_q[DivSteps];
    mq      = dv_last.m_low;
    if (dv_last.tot_zero) begin
      meas = ProbHalf;
    end else if (mq > {1'b0, ProbMax}) begin
      meas = ProbMax;
    end else if (mq < {1'b0, ProbMin}) begin
      meas = ProbMin;
    end else begin
      meas = mq[ProbW-1:0];
    end
    old_w = ProbOne - {1'b0, dv_last.f_low};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgMul] && v_q[StgMul-1]) begin
      pa_q      <= dv_last.old * old_w;
      pb_q      <= meas * dv_last.f_low;
      s11_old_q <= dv_last.old;
      s11_bad_q <= dv_last.sat_zero;
    end
  end

  // ---------------------------------------------------------------- blend and output
  logic [2*ProbW+1:0] blend_sum;
  logic [ProbW+1:0]   blend;
  logic [ProbW-1:0]   new_d, new_q;
  logic               bad_q;

  always_comb begin
    blend_sum = {1'b0, pa_q} + {2'b00, pb_q} + (2*ProbW+2)'(ProbHalf);
    blend     = blend_sum[2*ProbW+1 -: ProbW+2];
    if (s11_bad_q) begin
      new_d = s11_old_q;
    end else if (blend > {2'b00, ProbMax}) begin
      new_d = ProbMax;
    end else begin
      new_d = blend[ProbW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgOut] && v_q[StgOut-1]) begin
      new_q <= new_d;
      bad_q <= s11_bad_q;
    end
  end

  assign out_valid_o       = v_q[StgOut];
  assign new_probability_o = new_q;
  assign bad_saturation_o  = bad_q;

endmodule

// ----- hdl/pma_checker.sv -----
module pma_checker
  import pma_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ProbW-1:0] new_probability_o,
  input logic             bad_saturation_o
);

  // input may only back up when a finished item is held by the receiver
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output item");

  // a held output item keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(new_probability_o) && $stable(bad_saturation_o)))
    else $error("output item changed while stalled");

  // no output item straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind probability_merge_adapt_unit pma_checker u_pma_checker (.*);
